// ===== design/ppt_pkg.sv =====
package ppt_pkg;

	// Default widths of the angle path and the timestamp arithmetic
	localparam int ANGLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths
	localparam int RAW_ANGLE_W = 16;
	localparam int NOW_W       = 32;
	localparam int TORQUE_W    = 15;
	localparam int FAULT_W     = 4;
	localparam int SHOWN_W     = 12;
	localparam int BAND_W      = 12;
	localparam int GAIN_W      = 20;
	localparam int KILL_TIME_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 40;

	localparam logic [TORQUE_W-1:0] TORQUE_MAX = 15'h7FFF;
	localparam logic [SHOWN_W-1:0]  SHOWN_MAX  = 12'hFFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_BAND_BOTTOM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_TORQUE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_TIME    = 3'd5;

	// Configuration reset values
	localparam logic [BAND_W-1:0]      ZERO_BAND_TOP_RST    = 12'd511;
	localparam logic [BAND_W-1:0]      FULL_BAND_BOTTOM_RST = 12'd3754;
	localparam logic [GAIN_W-1:0]      TORQUE_GAIN_RST      = 20'd441720;
	localparam logic [TORQUE_W-1:0]    FULL_TORQUE_RST      = 15'd21844;
	localparam logic [BAND_W-1:0]      MISMATCH_LIMIT_RST   = 12'd360;
	localparam logic [KILL_TIME_W-1:0] MISMATCH_TIME_RST    = 32'd100000;

	// Fault codes
	localparam logic [FAULT_W-1:0] F_NONE     = 4'd0;
	localparam logic [FAULT_W-1:0] F_STOP     = 4'd1;
	localparam logic [FAULT_W-1:0] F_SENS_A   = 4'd2;
	localparam logic [FAULT_W-1:0] F_SENS_B   = 4'd3;
	localparam logic [FAULT_W-1:0] F_RANGE    = 4'd4;
	localparam logic [FAULT_W-1:0] F_IMPL     = 4'd5;
	localparam logic [FAULT_W-1:0] F_NOTREADY = 4'd6;
	localparam logic [FAULT_W-1:0] F_TIMEOUT  = 4'd7;
	localparam logic [FAULT_W-1:0] F_BOTH     = 4'd8;
	localparam logic [FAULT_W-1:0] F_TRAVEL   = 4'd9;

endpackage

// ===== design/pedal_plausibility_torque_map.sv =====
// Pedal plausibility check and torque map. Each input transaction carries one sample of the
// two redundant pedal angle sensors; each one yields exactly one result transaction with the
// torque command, the latched shutdown state, the sticky first-fault code, the torque-kill
// flag and the angle mismatch. The block accepts one transaction per clock cycle while the
// result stream is not stalled. A taken sample sits in the input register and moves to the
// result register when that register is empty or being drained; the shutdown latch, fault
// code, mismatch timer and kill flag are updated in that same move, so consecutive samples
// chain without gaps. Configuration writes take effect on the next sample and belong only to
// idle periods. The shutdown latch stays open until reset.
module pedal_plausibility_torque_map #(
	parameter int ANGLE_BITS = ppt_pkg::ANGLE_BITS_DEF,
	parameter int TIME_BITS  = ppt_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data,
	// sample stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata, low bit up: stop_request(1), angle_a(16), angle_b(16), sensor_a_failed(1),
	// sensor_b_failed(1), ready_to_drive(1), now_us(32), zero fill(4)
	input  logic [ppt_pkg::IN_DATA_W-1:0]  s_tdata,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata, low bit up: torque_command(15), shutdown_open(1), fault_code(4),
	// torque_killed(1), angle_mismatch(12), zero fill(7)
	output logic [ppt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ppt_pkg::*;

	localparam logic [RAW_ANGLE_W:0]  ANGLE_LIMIT = (RAW_ANGLE_W+1)'(1) << ANGLE_BITS;
	localparam logic [ANGLE_BITS-1:0] ANGLE_MAX   = {ANGLE_BITS{1'b1}};
	localparam int                    PROD_W      = RAW_ANGLE_W + GAIN_W;

	// configuration registers
	logic [BAND_W-1:0]      zero_band_top_q;
	logic [BAND_W-1:0]      full_band_bottom_q;
	logic [GAIN_W-1:0]      torque_gain_q;
	logic [TORQUE_W-1:0]    full_torque_q;
	logic [BAND_W-1:0]      mismatch_limit_q;
	logic [KILL_TIME_W-1:0] mismatch_time_q;

	// block state
	logic                 shutdown_q;
	logic [FAULT_W-1:0]   first_fault_q;
	logic [TIME_BITS-1:0] mismatch_start_q;
	logic                 kill_q;

	// input stage
	logic                   valid_s1;
	logic                   stop_s1;
	logic [RAW_ANGLE_W-1:0] raw_a_s1;
	logic [RAW_ANGLE_W-1:0] raw_b_s1;
	logic                   fail_a_s1;
	logic                   fail_b_s1;
	logic                   ready_s1;
	logic [NOW_W-1:0]       now_s1;

	// result stage
	logic                   valid_s2;
	logic [TORQUE_W-1:0]    torque_s2;
	logic                   shutdown_s2;
	logic [FAULT_W-1:0]     fault_s2;
	logic                   kill_s2;
	logic [SHOWN_W-1:0]     shown_s2;

	logic advance;

	// combinational datapath
	logic                   range_a;
	logic                   range_b;
	logic [ANGLE_BITS-1:0]  ang_a;
	logic [ANGLE_BITS-1:0]  ang_b;
	logic [ANGLE_BITS-1:0]  delta;
	logic [ANGLE_BITS-1:0]  lo;
	logic                   plausible;
	logic [TIME_BITS-1:0]   now_t;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   timeout;
	logic                   kill_nxt;
	logic                   travel;
	logic [RAW_ANGLE_W-1:0] lo_w;
	logic [RAW_ANGLE_W-1:0] offset;
	logic [PROD_W-1:0]      product;
	logic [GAIN_W-1:0]      scaled;
	logic [TORQUE_W-1:0]    lin_torque;
	logic [TORQUE_W-1:0]    map_torque;
	logic [TORQUE_W-1:0]    torque_nxt;
	logic                   gated;
	logic                   latch_evt;
	logic [FAULT_W-1:0]     cand_fault;
	logic [FAULT_W-1:0]     fault_nxt;
	logic [SHOWN_W-1:0]     shown_nxt;

	// Move a sample into the result register when it is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_band_top_q    <= ZERO_BAND_TOP_RST;
			full_band_bottom_q <= FULL_BAND_BOTTOM_RST;
			torque_gain_q      <= TORQUE_GAIN_RST;
			full_torque_q      <= FULL_TORQUE_RST;
			mismatch_limit_q   <= MISMATCH_LIMIT_RST;
			mismatch_time_q    <= MISMATCH_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_BAND_TOP:    zero_band_top_q    <= cfg_data[BAND_W-1:0];
				REG_FULL_BAND_BOTTOM: full_band_bottom_q <= cfg_data[BAND_W-1:0];
				REG_TORQUE_GAIN:      torque_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_FULL_TORQUE:      full_torque_q      <= cfg_data[TORQUE_W-1:0];
				REG_MISMATCH_LIMIT:   mismatch_limit_q   <= cfg_data[BAND_W-1:0];
				REG_MISMATCH_TIME:    mismatch_time_q    <= cfg_data[KILL_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: unpack the sample
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			stop_s1   <= s_tdata[0];
			raw_a_s1  <= s_tdata[16:1];
			raw_b_s1  <= s_tdata[32:17];
			fail_a_s1 <= s_tdata[33];
			fail_b_s1 <= s_tdata[34];
			ready_s1  <= s_tdata[35];
			now_s1    <= s_tdata[67:36];
		end
	end

	// Qualify both angles: a failed read or an out-of-range value reads as zero
	always_comb begin
		range_a = ((RAW_ANGLE_W+1)'(raw_a_s1) >= ANGLE_LIMIT);
		range_b = ((RAW_ANGLE_W+1)'(raw_b_s1) >= ANGLE_LIMIT);
		ang_a   = (fail_a_s1 || range_a) ? '0 : raw_a_s1[ANGLE_BITS-1:0];
		ang_b   = (fail_b_s1 || range_b) ? '0 : raw_b_s1[ANGLE_BITS-1:0];
		delta   = (ang_a > ang_b) ? (ang_a - ang_b) : (ang_b - ang_a);
		lo      = (ang_a < ang_b) ? ang_a : ang_b;
		shown_nxt = (RAW_ANGLE_W'(delta) > RAW_ANGLE_W'(SHOWN_MAX)) ? SHOWN_MAX
			: SHOWN_W'(delta);
	end

	// Mismatch timer and kill decision
	always_comb begin
		now_t     = TIME_BITS'({32'd0, now_s1});
		plausible = (RAW_ANGLE_W'(delta) < RAW_ANGLE_W'(mismatch_limit_q));
		elapsed   = now_t - mismatch_start_q;
		timeout   = (64'(elapsed) > 64'(mismatch_time_q));
		if (stop_s1) begin
			kill_nxt = kill_q;
		end else if (plausible) begin
			kill_nxt = 1'b0;
		end else if (timeout) begin
			kill_nxt = 1'b1;
		end else begin
			kill_nxt = kill_q;
		end
	end

	// Torque map: travel ends, dead band, full band, then linear band
	always_comb begin
		travel     = (lo == '0) || (lo == ANGLE_MAX);
		lo_w       = RAW_ANGLE_W'(lo);
		offset     = lo_w - RAW_ANGLE_W'(zero_band_top_q) - RAW_ANGLE_W'(1);
		product    = PROD_W'(offset) * PROD_W'(torque_gain_q);
		scaled     = product[PROD_W-1:16];
		lin_torque = (scaled > GAIN_W'(TORQUE_MAX)) ? TORQUE_MAX : scaled[TORQUE_W-1:0];
		if (travel) begin
			map_torque = '0;
		end else if (lo_w <= RAW_ANGLE_W'(zero_band_top_q)) begin
			map_torque = '0;
		end else if (lo_w >= RAW_ANGLE_W'(full_band_bottom_q)) begin
			map_torque = full_torque_q;
		end else begin
			map_torque = lin_torque;
		end
		gated      = !ready_s1 || kill_nxt;
		torque_nxt = (stop_s1 || gated) ? '0 : map_torque;
	end

	// Pick the first fault raised by this sample, in processing order
	always_comb begin
		latch_evt = stop_s1 || fail_a_s1 || range_a || fail_b_s1 || range_b || travel;
		if (stop_s1) begin
			cand_fault = F_STOP;
		end else if (fail_a_s1) begin
			cand_fault = F_SENS_A;
		end else if (range_a) begin
			cand_fault = F_RANGE;
		end else if (fail_b_s1) begin
			cand_fault = F_SENS_B;
		end else if (range_b) begin
			cand_fault = F_RANGE;
		end else if (!plausible) begin
			cand_fault = F_IMPL;
		end else if (travel) begin
			cand_fault = F_TRAVEL;
		end else if (!ready_s1 && kill_nxt) begin
			cand_fault = F_BOTH;
		end else if (!ready_s1) begin
			cand_fault = F_NOTREADY;
		end else if (kill_nxt) begin
			cand_fault = F_TIMEOUT;
		end else begin
			cand_fault = F_NONE;
		end
		fault_nxt = (first_fault_q != F_NONE) ? first_fault_q : cand_fault;
	end

	// Update block state as each sample completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shutdown_q       <= 1'b0;
			first_fault_q    <= F_NONE;
			mismatch_start_q <= '0;
			kill_q           <= 1'b0;
		end else if (advance) begin
			shutdown_q    <= shutdown_q || latch_evt;
			first_fault_q <= fault_nxt;
			kill_q        <= kill_nxt;
			if (!stop_s1 && plausible) begin
				mismatch_start_q <= now_t;
			end
		end
	end

	// Result register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			torque_s2   <= torque_nxt;
			shutdown_s2 <= shutdown_q || latch_evt;
			fault_s2    <= fault_nxt;
			kill_s2     <= kill_nxt;
			shown_s2    <= stop_s1 ? '0 : shown_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, shown_s2, kill_s2, fault_s2, shutdown_s2, torque_s2};

endmodule

// ===== design/ppt_checker.sv =====
module ppt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ppt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ppt_pkg::*;

	logic                 out_acc;
	logic                 seen_open_q;
	logic [FAULT_W-1:0]   seen_fault_q;
	logic [TORQUE_W-1:0]  torque;
	logic                 shut_open;
	logic [FAULT_W-1:0]   fault;
	logic                 killed;

	assign out_acc   = m_tvalid && m_tready;
	assign torque    = m_tdata[14:0];
	assign shut_open = m_tdata[15];
	assign fault     = m_tdata[19:16];
	assign killed    = m_tdata[20];

	// Track what earlier result transactions have shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_open_q  <= 1'b0;
			seen_fault_q <= F_NONE;
		end else if (out_acc) begin
			seen_open_q  <= seen_open_q || shut_open;
			if (seen_fault_q == F_NONE) begin
				seen_fault_q <= fault;
			end
		end
	end

	// Once opened, the shutdown latch stays open
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && seen_open_q) |-> shut_open)
		else $error("shutdown latch closed again");

	// The first fault code never changes once set
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && (seen_fault_q != F_NONE)) |-> (fault == seen_fault_q))
		else $error("first fault code changed");

	// Killed torque is never commanded
	a_kill_gates: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && killed) |-> (torque == '0))
		else $error("torque commanded while killed");

	// A kill always leaves a fault behind
	a_kill_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && killed) |-> (fault != F_NONE))
		else $error("torque killed with no fault recorded");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind pedal_plausibility_torque_map ppt_checker u_ppt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/pedal_plausibility_torque_map_test.sv =====
module pedal_plausibility_torque_map_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppt_pkg::*;

	localparam int ANGLE_TOP       = (1 << ANGLE_BITS_DEF) - 1;
	localparam int DIRECTED_ROWS   = 24;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 43;
	localparam int CYCLE_LIMIT     = 200000;

	// One pedal sample; the first member sits in the highest bits, so the cast
	// to s_tdata puts stop_request at bit 0
	typedef struct packed {
		logic [NOW_W-1:0]       now_us;
		logic                   ready;
		logic                   fail_b;
		logic                   fail_a;
		logic [RAW_ANGLE_W-1:0] angle_b;
		logic [RAW_ANGLE_W-1:0] angle_a;
		logic                   stop;
	} sample_t;

	// One result, laid out as in m_tdata
	typedef struct packed {
		logic [SHOWN_W-1:0]  angle_mismatch;
		logic                torque_killed;
		logic [FAULT_W-1:0]  fault_code;
		logic                shutdown_open;
		logic [TORQUE_W-1:0] torque;
	} result_t;

	typedef struct {
		logic [BAND_W-1:0]      zero_top;
		logic [BAND_W-1:0]      full_bottom;
		logic [GAIN_W-1:0]      gain;
		logic [TORQUE_W-1:0]    full;
		logic [BAND_W-1:0]      limit;
		logic [KILL_TIME_W-1:0] kill_time;
	} reg_set_t;

	// Directed row: sample fields, then an optional hand-typed result
	typedef struct {
		bit               stop;
		int               a;
		int               b;
		bit               fa;
		bit               fb;
		bit               rdy;
		logic [NOW_W-1:0] now;
		bit               pinned;
		int               torque;
		bit               shut;
		logic [3:0]       fault;
		bit               killed;
		int               mismatch;
	} row_t;

	localparam int SAMPLE_W = $bits(sample_t);
	localparam int RESULT_W = $bits(result_t);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Mirror of the configuration registers
	logic [BAND_W-1:0]      dead_band_top;
	logic [BAND_W-1:0]      full_band_floor;
	logic [GAIN_W-1:0]      gain_q16;
	logic [TORQUE_W-1:0]    full_band_torque;
	logic [BAND_W-1:0]      plausibility_limit;
	logic [KILL_TIME_W-1:0] kill_time_us;

	// Mirror of the block state
	logic               latch_open;
	logic [FAULT_W-1:0] first_fault_code;
	logic [NOW_W-1:0]   mismatch_since_us;
	logic               kill_active;

	result_t expected_results[$];
	result_t pinned_results[int];
	int      samples_taken = 0;
	int      items_sent = 0;
	int      results_checked = 0;
	int      mismatches = 0;
	int      cycle_count = 0;
	int      stall_left = 0;
	logic    idling_on = 1'b0;
	logic [NOW_W-1:0] clock_us = '0;

	row_t directed_rows[DIRECTED_ROWS] = '{
		'{0, 2000, 2000, 0, 0, 1, 32'd10, 0, 0, 0, F_NONE, 0, 0},
		'{0, 300, 310, 0, 0, 1, 32'd20, 1, 0, 0, F_NONE, 0, 10},
		'{0, 4000, 3900, 0, 0, 1, 32'd30, 1, FULL_TORQUE_RST, 0, F_NONE, 0, 100},
		'{0, 512, 600, 0, 0, 1, 32'd40, 1, 0, 0, F_NONE, 0, 88},
		'{0, 3753, 3753, 0, 0, 1, 32'd50, 0, 0, 0, F_NONE, 0, 0},
		'{0, 2000, 2000, 0, 0, 0, 32'd60, 1, 0, 0, F_NOTREADY, 0, 0},
		'{0, 4095, 4095, 0, 0, 1, 32'd70, 1, 0, 1, F_NOTREADY, 0, 0},
		'{0, 0, 0, 0, 0, 1, 32'd80, 1, 0, 1, F_NOTREADY, 0, 0},
		'{0, 4096, 2000, 0, 0, 1, 32'd90, 1, 0, 1, F_NOTREADY, 0, 2000},
		'{0, 'hFFFF, 'hFFFF, 0, 0, 1, 32'd100, 1, 0, 1, F_NOTREADY, 0, 0},
		'{0, 2000, 2000, 1, 0, 1, 32'd110, 1, 0, 1, F_NOTREADY, 0, 2000},
		'{0, 1500, 1500, 0, 1, 1, 32'd120, 1, 0, 1, F_NOTREADY, 0, 1500},
		'{0, 'hFFFF, 'hFFFF, 1, 1, 1, 32'd500, 1, 0, 1, F_NOTREADY, 0, 0},
		'{0, 1000, 1500, 0, 0, 1, 32'd600, 0, 0, 0, F_NONE, 0, 0},
		'{0, 1000, 1500, 0, 0, 1, 32'd100600, 1, 0, 1, F_NOTREADY, 1, 500},
		'{1, 'hFFFF, 1234, 1, 0, 0, 32'd100650, 1, 0, 1, F_NOTREADY, 1, 0},
		'{0, 1200, 1200, 0, 0, 1, 32'd100700, 0, 0, 0, F_NONE, 0, 0},
		'{0, 3000, 3000, 0, 0, 1, 32'hFFFF_FFF0, 0, 0, 0, F_NONE, 0, 0},
		'{0, 3000, 3400, 0, 0, 1, 32'h0001_0000, 0, 0, 0, F_NONE, 0, 0},
		'{0, 3000, 3400, 0, 0, 1, 32'h0002_0000, 1, 0, 1, F_NOTREADY, 1, 400},
		'{0, 3400, 3000, 0, 0, 0, 32'h0002_0010, 1, 0, 1, F_NOTREADY, 1, 400},
		'{0, 4095, 0, 0, 0, 1, 32'h0002_0020, 1, 0, 1, F_NOTREADY, 1, 4095},
		'{0, 1234, 1234, 0, 0, 1, 32'h0002_0030, 0, 0, 0, F_NONE, 0, 0},
		'{0, 'hF00F, 'h0AAA, 0, 0, 1, 32'h0002_0040, 1, 0, 1, F_NOTREADY, 0, 2730}
	};

	pedal_plausibility_torque_map uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void restore_defaults();
		dead_band_top = ZERO_BAND_TOP_RST;
		full_band_floor = FULL_BAND_BOTTOM_RST;
		gain_q16 = TORQUE_GAIN_RST;
		full_band_torque = FULL_TORQUE_RST;
		plausibility_limit = MISMATCH_LIMIT_RST;
		kill_time_us = MISMATCH_TIME_RST;
		latch_open = 1'b0;
		first_fault_code = F_NONE;
		mismatch_since_us = '0;
		kill_active = 1'b0;
	endfunction

	// Keep only the first fault code
	function automatic void note_fault(logic [FAULT_W-1:0] code);
		if (first_fault_code == F_NONE)
			first_fault_code = code;
	endfunction

	function automatic void open_shutdown(logic [FAULT_W-1:0] code);
		latch_open = 1'b1;
		note_fault(code);
	endfunction

	// Zero a failed or out-of-range reading
	function automatic int qualify_angle(logic [RAW_ANGLE_W-1:0] raw, logic failed,
			logic [FAULT_W-1:0] fail_code);
		if (failed) begin
			open_shutdown(fail_code);
			return 0;
		end
		if (int'(raw) > ANGLE_TOP) begin
			open_shutdown(F_RANGE);
			return 0;
		end
		return int'(raw);
	endfunction

	// Travel ends, dead band, then full band, then the linear Q16 band
	function automatic int torque_for_angle(int x);
		longint unsigned prod;
		if (x == 0 || x == ANGLE_TOP) begin
			open_shutdown(F_TRAVEL);
			return 0;
		end
		if (x <= int'(dead_band_top))
			return 0;
		if (x >= int'(full_band_floor))
			return int'(full_band_torque);
		prod = (longint'(x - int'(dead_band_top) - 1) * longint'(gain_q16)) >> 16;
		return (prod > TORQUE_MAX) ? int'(TORQUE_MAX) : int'(prod);
	endfunction

	// Advance the mirrored state by one sample and return its result
	function automatic result_t predict_result(sample_t smp);
		int qa;
		int qb;
		int diff;
		int lo;
		logic [NOW_W-1:0] elapsed;
		result_t r;
		r = '0;
		if (smp.stop) begin
			open_shutdown(F_STOP);
		end else begin
			qa = qualify_angle(smp.angle_a, smp.fail_a, F_SENS_A);
			qb = qualify_angle(smp.angle_b, smp.fail_b, F_SENS_B);
			diff = (qa > qb) ? qa - qb : qb - qa;
			r.angle_mismatch = (diff > int'(SHOWN_MAX)) ? SHOWN_MAX : SHOWN_W'(diff);
			if (diff < int'(plausibility_limit)) begin
				kill_active = 1'b0;
				mismatch_since_us = smp.now_us;
			end else begin
				note_fault(F_IMPL);
				elapsed = smp.now_us - mismatch_since_us;
				if (elapsed > kill_time_us) begin
					note_fault(F_TIMEOUT);
					kill_active = 1'b1;
				end
			end
			lo = (qa < qb) ? qa : qb;
			r.torque = TORQUE_W'(torque_for_angle(lo));
			if (!smp.ready || kill_active) begin
				r.torque = '0;
				if (!smp.ready && kill_active)
					note_fault(F_BOTH);
				else if (!smp.ready)
					note_fault(F_NOTREADY);
				else
					note_fault(F_TIMEOUT);
			end
		end
		r.shutdown_open = latch_open;
		r.fault_code = first_fault_code;
		r.torque_killed = kill_active;
		return r;
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0d, got %0d", results_checked, field, want, got);
		end
	endtask

	// Track register writes, predict on each accepted sample, check each result
	always @(posedge clk) begin
		result_t predicted;
		result_t want;
		result_t got;
		if (!arst_n) begin
			restore_defaults();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_BAND_TOP:    dead_band_top = cfg_data[BAND_W-1:0];
					REG_FULL_BAND_BOTTOM: full_band_floor = cfg_data[BAND_W-1:0];
					REG_TORQUE_GAIN:      gain_q16 = cfg_data[GAIN_W-1:0];
					REG_FULL_TORQUE:      full_band_torque = cfg_data[TORQUE_W-1:0];
					REG_MISMATCH_LIMIT:   plausibility_limit = cfg_data[BAND_W-1:0];
					REG_MISMATCH_TIME:    kill_time_us = cfg_data[KILL_TIME_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predicted = predict_result(sample_t'(s_tdata[SAMPLE_W-1:0]));
				if (pinned_results.exists(samples_taken))
					expected_results.push_back(pinned_results[samples_taken]);
				else
					expected_results.push_back(predicted);
				samples_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_W-1:0]);
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with nothing expected", results_checked);
				end else begin
					want = expected_results.pop_front();
					check_field("torque_command", want.torque, got.torque);
					check_field("shutdown_open", want.shutdown_open, got.shutdown_open);
					check_field("fault_code", want.fault_code, got.fault_code);
					check_field("torque_killed", want.torque_killed, got.torque_killed);
					check_field("angle_mismatch", want.angle_mismatch, got.angle_mismatch);
				end
				results_checked <= results_checked + 1;
			end
		end
	end

	// Result-side backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Hold one sample until it is taken, then maybe idle for a burst
	task automatic send_sample(sample_t smp);
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(smp);
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_checked != items_sent);
	endtask

	task automatic program_regs(reg_set_t r);
		cfg_we <= 1'b1;
		cfg_index <= REG_ZERO_BAND_TOP;
		cfg_data <= CFG_DATA_W'(r.zero_top);
		@(posedge clk);
		cfg_index <= REG_FULL_BAND_BOTTOM;
		cfg_data <= CFG_DATA_W'(r.full_bottom);
		@(posedge clk);
		cfg_index <= REG_TORQUE_GAIN;
		cfg_data <= CFG_DATA_W'(r.gain);
		@(posedge clk);
		cfg_index <= REG_FULL_TORQUE;
		cfg_data <= CFG_DATA_W'(r.full);
		@(posedge clk);
		cfg_index <= REG_MISMATCH_LIMIT;
		cfg_data <= CFG_DATA_W'(r.limit);
		@(posedge clk);
		cfg_index <= REG_MISMATCH_TIME;
		cfg_data <= CFG_DATA_W'(r.kill_time);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Defaults, both extremes, a saturating linear map, then random settings
	function automatic reg_set_t pick_regs(int phase);
		reg_set_t r;
		case (phase)
			0, PHASES - 1: r = '{ZERO_BAND_TOP_RST, FULL_BAND_BOTTOM_RST, TORQUE_GAIN_RST,
				FULL_TORQUE_RST, MISMATCH_LIMIT_RST, MISMATCH_TIME_RST};
			1: r = '{'0, '0, '0, '0, '0, '0};
			2: r = '{'1, '1, '1, '1, '1, '1};
			3: r = '{'0, '1, '1, '1, 12'd200, 32'd50000};
			PHASES - 2: begin
				r.zero_top = BAND_W'($urandom_range(0, ANGLE_TOP));
				r.full_bottom = BAND_W'($urandom_range(0, ANGLE_TOP));
				r.gain = GAIN_W'($urandom_range(0, 20'hFFFFF));
				r.full = TORQUE_W'($urandom_range(0, 15'h7FFF));
				r.limit = BAND_W'($urandom_range(0, ANGLE_TOP));
				r.kill_time = $urandom_range(0, 300000);
			end
			default: begin
				r.zero_top = BAND_W'($urandom_range(0, 2000));
				r.full_bottom = BAND_W'($urandom_range(2000, ANGLE_TOP));
				r.gain = GAIN_W'($urandom_range(0, 20'hFFFFF));
				r.full = TORQUE_W'($urandom_range(0, 15'h7FFF));
				r.limit = BAND_W'($urandom_range(0, 1000));
				r.kill_time = $urandom_range(0, 300000);
			end
		endcase
		return r;
	endfunction

	function automatic int clamp_angle(int x);
		return (x < 0) ? 0 : ((x > ANGLE_TOP) ? ANGLE_TOP : x);
	endfunction

	// Pairs often near the band edges or travel ends, with faults mixed in
	function automatic sample_t random_sample();
		sample_t smp;
		int base;
		int off;
		int other;
		smp = '0;
		smp.stop = ($urandom_range(0, 24) == 0);
		smp.ready = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 11))
			0: base = 0;
			1: base = ANGLE_TOP;
			2: base = int'(dead_band_top);
			3: base = int'(dead_band_top) + 1;
			4: base = int'(full_band_floor);
			5: base = int'(full_band_floor) - 1;
			default: base = $urandom_range(0, ANGLE_TOP);
		endcase
		base = clamp_angle(base);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: off = $urandom_range(0, 2 * int'(plausibility_limit) + 1);
			6, 7: off = $urandom_range(0, ANGLE_TOP);
			default: off = 0;
		endcase
		other = clamp_angle($urandom_range(0, 1) ? base + off : base - off);
		smp.angle_a = RAW_ANGLE_W'(base);
		smp.angle_b = RAW_ANGLE_W'(other);
		if ($urandom_range(0, 15) == 0)
			smp.angle_a = RAW_ANGLE_W'($urandom_range(ANGLE_TOP + 1, 65535));
		if ($urandom_range(0, 15) == 0)
			smp.angle_b = RAW_ANGLE_W'($urandom_range(ANGLE_TOP + 1, 65535));
		smp.fail_a = ($urandom_range(0, 19) == 0);
		smp.fail_b = ($urandom_range(0, 19) == 0);
		// Advance the timestamp; jump long enough to kill torque now and then
		case ($urandom_range(0, 19))
			0: clock_us = $urandom();
			1, 2: clock_us = clock_us + $urandom_range(50000, 250000);
			default: clock_us = clock_us + $urandom_range(0, 4000);
		endcase
		smp.now_us = clock_us;
		return smp;
	endfunction

	initial begin
		sample_t smp;
		result_t pin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		idling_on <= 1'b1;
		@(posedge clk);

		// Directed rows with the settings from reset
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			smp.stop = directed_rows[row].stop;
			smp.angle_a = RAW_ANGLE_W'(directed_rows[row].a);
			smp.angle_b = RAW_ANGLE_W'(directed_rows[row].b);
			smp.fail_a = directed_rows[row].fa;
			smp.fail_b = directed_rows[row].fb;
			smp.ready = directed_rows[row].rdy;
			smp.now_us = directed_rows[row].now;
			if (directed_rows[row].pinned) begin
				pin.torque = TORQUE_W'(directed_rows[row].torque);
				pin.shutdown_open = directed_rows[row].shut;
				pin.fault_code = directed_rows[row].fault;
				pin.torque_killed = directed_rows[row].killed;
				pin.angle_mismatch = SHOWN_W'(directed_rows[row].mismatch);
				pinned_results[items_sent] = pin;
			end
			send_sample(smp);
		end
		clock_us = directed_rows[DIRECTED_ROWS - 1].now;

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			idling_on <= (phase % 3 != 2) && (phase != PHASES - 1);
			program_regs(pick_regs(phase));
			repeat (ITEMS_PER_PHASE) send_sample(random_sample());
		end

		settle();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
